@@ src/rgbpk_pkg.sv @@
`default_nettype none

package rgbpk_pkg;

    localparam int CHAN_W  = 8;
    localparam int SCALE_W = 16;
    localparam int PIX_W   = 16;
    localparam int SHIFT_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // floor(x * c / 1000) == (x * c * ceil(2^27 / 1000)) >> 27, exact for x * c < 493446
    localparam int LUMA_SHIFT = 27;
    localparam int LUMA_KW    = 27;
    localparam logic [LUMA_KW-1:0] LUMA_K_R = 27'd40131182;
    localparam logic [LUMA_KW-1:0] LUMA_K_G = 27'd78785966;
    localparam logic [LUMA_KW-1:0] LUMA_K_B = 27'd15300852;

    localparam logic [CHAN_W-1:0] CHAN_MAX      = 8'd255;
    localparam logic [PIX_W-1:0]  BLACK_STANDIN = 16'h0001;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MONO_MODE   = 3'd0,
        CFG_RED_SHIFT   = 3'd1,
        CFG_GREEN_SHIFT = 3'd2,
        CFG_BLUE_SHIFT  = 3'd3,
        CFG_RED_MASK    = 3'd4,
        CFG_GREEN_MASK  = 3'd5,
        CFG_BLUE_MASK   = 3'd6,
        CFG_ALPHA_MASK  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                      mono_mode;
        logic signed [SHIFT_W-1:0] red_shift;
        logic signed [SHIFT_W-1:0] green_shift;
        logic signed [SHIFT_W-1:0] blue_shift;
        logic [PIX_W-1:0]          red_mask;
        logic [PIX_W-1:0]          green_mask;
        logic [PIX_W-1:0]          blue_mask;
        logic [PIX_W-1:0]          alpha_mask;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic [SCALE_W-1:0] r;
        logic [SCALE_W-1:0] g;
        logic [SCALE_W-1:0] b;
    } t_scale;

endpackage

`default_nettype wire

@@ src/shaded_rgb_to_16bit_pixel_pack_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_red i_green i_blue, *_scale
// out       output     o_out_valid / i_out_stall o_pixel
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// One color per cycle while the output is not stalled, through the luma product,
// luma sum, scale multiply and pack register stages.
// Each stage takes a new item when empty or when the stage after it moves on,
// so bubbles close up under an output stall and nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline and clears the config registers; data registers are not reset.
// The config port never stalls.
module shaded_rgb_to_16bit_pixel_pack_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [rgbpk_pkg::CHAN_W-1:0]       i_red,
    input  wire logic [rgbpk_pkg::CHAN_W-1:0]       i_green,
    input  wire logic [rgbpk_pkg::CHAN_W-1:0]       i_blue,
    input  wire logic [rgbpk_pkg::SCALE_W-1:0]      i_red_scale,
    input  wire logic [rgbpk_pkg::SCALE_W-1:0]      i_green_scale,
    input  wire logic [rgbpk_pkg::SCALE_W-1:0]      i_blue_scale,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [rgbpk_pkg::PIX_W-1:0]             o_pixel,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [rgbpk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rgbpk_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    rgbpk_pkg::t_cfg    cfg;
    rgbpk_pkg::t_rgb    in_rgb;
    rgbpk_pkg::t_scale  in_scale;
    logic               luma_ready;
    logic               luma_valid;
    rgbpk_pkg::t_rgb    luma_chan;
    rgbpk_pkg::t_scale  luma_scale;
    logic               scale_ready;
    logic               scale_valid;
    rgbpk_pkg::t_rgb    scale_chan;
    logic               pack_ready;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_rgb.r   = i_red;
        in_rgb.g   = i_green;
        in_rgb.b   = i_blue;
        in_scale.r = i_red_scale;
        in_scale.g = i_green_scale;
        in_scale.b = i_blue_scale;
    end

    rgbpk_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rgbpk_luma u_luma (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mono_mode  (cfg.mono_mode),
        .i_valid      (i_in_valid),
        .i_rgb        (in_rgb),
        .i_scale      (in_scale),
        .o_ready      (luma_ready),
        .i_ready_next (scale_ready),
        .o_valid      (luma_valid),
        .o_chan       (luma_chan),
        .o_scale      (luma_scale)
    );

    rgbpk_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (luma_valid),
        .i_chan       (luma_chan),
        .i_scale      (luma_scale),
        .o_ready      (scale_ready),
        .i_ready_next (pack_ready),
        .o_valid      (scale_valid),
        .o_chan       (scale_chan)
    );

    rgbpk_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (scale_valid),
        .i_chan  (scale_chan),
        .o_ready (pack_ready),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_pixel (o_pixel)
    );

    assign o_in_stall = !luma_ready;

endmodule

`default_nettype wire

@@ src/rgbpk_cfg.sv @@
`default_nettype none

module rgbpk_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [rgbpk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rgbpk_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rgbpk_pkg::t_cfg                         o_cfg
);

    rgbpk_pkg::t_cfg r_cfg;
    rgbpk_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (rgbpk_pkg::t_cfg_idx'(i_cfg_index))
                rgbpk_pkg::CFG_MONO_MODE:   n_cfg.mono_mode   = i_cfg_data[0];
                rgbpk_pkg::CFG_RED_SHIFT:   n_cfg.red_shift   = i_cfg_data[rgbpk_pkg::SHIFT_W-1:0];
                rgbpk_pkg::CFG_GREEN_SHIFT: n_cfg.green_shift = i_cfg_data[rgbpk_pkg::SHIFT_W-1:0];
                rgbpk_pkg::CFG_BLUE_SHIFT:  n_cfg.blue_shift  = i_cfg_data[rgbpk_pkg::SHIFT_W-1:0];
                rgbpk_pkg::CFG_RED_MASK:    n_cfg.red_mask    = i_cfg_data;
                rgbpk_pkg::CFG_GREEN_MASK:  n_cfg.green_mask  = i_cfg_data;
                rgbpk_pkg::CFG_BLUE_MASK:   n_cfg.blue_mask   = i_cfg_data;
                rgbpk_pkg::CFG_ALPHA_MASK:  n_cfg.alpha_mask  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ src/rgbpk_luma.sv @@
`default_nettype none

module rgbpk_luma (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_mono_mode,
    input  wire logic               i_valid,
    input  wire rgbpk_pkg::t_rgb    i_rgb,
    input  wire rgbpk_pkg::t_scale  i_scale,
    output logic                    o_ready,
    input  wire logic               i_ready_next,
    output logic                    o_valid,
    output rgbpk_pkg::t_rgb         o_chan,
    output rgbpk_pkg::t_scale       o_scale
);

    localparam int PW = rgbpk_pkg::CHAN_W + rgbpk_pkg::LUMA_KW;

    logic                 r_v1;
    rgbpk_pkg::t_rgb      r_rgb1;
    rgbpk_pkg::t_rgb      r_term1;
    rgbpk_pkg::t_scale    r_scale1;
    logic                 r_v2;
    rgbpk_pkg::t_rgb      r_chan2;
    rgbpk_pkg::t_scale    r_scale2;

    logic                 ready2;
    logic [PW-1:0]        prod_r;
    logic [PW-1:0]        prod_g;
    logic [PW-1:0]        prod_b;
    rgbpk_pkg::t_rgb      n_term1;
    logic [rgbpk_pkg::CHAN_W+1:0] lum_sum;
    logic [rgbpk_pkg::CHAN_W-1:0] lum;
    rgbpk_pkg::t_rgb      n_chan2;

    assign ready2  = !r_v2 || i_ready_next;
    assign o_ready = !r_v1 || ready2;

    assign prod_r = PW'(i_rgb.r) * PW'(rgbpk_pkg::LUMA_K_R);
    assign prod_g = PW'(i_rgb.g) * PW'(rgbpk_pkg::LUMA_K_G);
    assign prod_b = PW'(i_rgb.b) * PW'(rgbpk_pkg::LUMA_K_B);

    always_comb begin
        n_term1.r = prod_r[PW-1:rgbpk_pkg::LUMA_SHIFT];
        n_term1.g = prod_g[PW-1:rgbpk_pkg::LUMA_SHIFT];
        n_term1.b = prod_b[PW-1:rgbpk_pkg::LUMA_SHIFT];
    end

    assign lum_sum = (rgbpk_pkg::CHAN_W+2)'(r_term1.r) + (rgbpk_pkg::CHAN_W+2)'(r_term1.g)
                   + (rgbpk_pkg::CHAN_W+2)'(r_term1.b);
    assign lum = lum_sum[rgbpk_pkg::CHAN_W-1:0];

    always_comb begin
        if (i_mono_mode) begin
            n_chan2.r = lum;
            n_chan2.g = lum;
            n_chan2.b = lum;
        end else begin
            n_chan2 = r_rgb1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rgb1   <= i_rgb;
            r_term1  <= n_term1;
            r_scale1 <= i_scale;
        end
        if (ready2) begin
            r_chan2  <= n_chan2;
            r_scale2 <= r_scale1;
        end
    end

    assign o_valid = r_v2;
    assign o_chan  = r_chan2;
    assign o_scale = r_scale2;

endmodule

`default_nettype wire

@@ src/rgbpk_scale.sv @@
`default_nettype none

module rgbpk_scale (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire rgbpk_pkg::t_rgb    i_chan,
    input  wire rgbpk_pkg::t_scale  i_scale,
    output logic                    o_ready,
    input  wire logic               i_ready_next,
    output logic                    o_valid,
    output rgbpk_pkg::t_rgb         o_chan
);

    localparam int MW = rgbpk_pkg::CHAN_W + rgbpk_pkg::SCALE_W;

    logic              r_v;
    rgbpk_pkg::t_rgb   r_chan;
    rgbpk_pkg::t_rgb   n_chan;

    function automatic logic [rgbpk_pkg::CHAN_W-1:0] scale_sat(
        input logic [rgbpk_pkg::CHAN_W-1:0]  c,
        input logic [rgbpk_pkg::SCALE_W-1:0] s
    );
        logic [MW-1:0] p;
        p = MW'(c) * MW'(s);
        if (p[MW-1:2*rgbpk_pkg::CHAN_W] != '0) begin
            return rgbpk_pkg::CHAN_MAX;
        end
        return p[2*rgbpk_pkg::CHAN_W-1:rgbpk_pkg::CHAN_W];
    endfunction

    always_comb begin
        n_chan.r = scale_sat(i_chan.r, i_scale.r);
        n_chan.g = scale_sat(i_chan.g, i_scale.g);
        n_chan.b = scale_sat(i_chan.b, i_scale.b);
    end

    assign o_ready = !r_v || i_ready_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_chan <= n_chan;
        end
    end

    assign o_valid = r_v;
    assign o_chan  = r_chan;

endmodule

`default_nettype wire

@@ src/rgbpk_pack.sv @@
`default_nettype none

module rgbpk_pack (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rgbpk_pkg::t_cfg               i_cfg,
    input  wire logic                          i_valid,
    input  wire rgbpk_pkg::t_rgb               i_chan,
    output logic                               o_ready,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [rgbpk_pkg::PIX_W-1:0]        o_pixel
);

    logic                          r_v;
    logic [rgbpk_pkg::PIX_W-1:0]   r_pixel;
    logic [rgbpk_pkg::PIX_W-1:0]   packed_pix;
    logic [rgbpk_pkg::PIX_W-1:0]   n_pixel;

    function automatic logic [rgbpk_pkg::PIX_W-1:0] place(
        input logic [rgbpk_pkg::CHAN_W-1:0]         c,
        input logic signed [rgbpk_pkg::SHIFT_W-1:0] sh
    );
        logic [rgbpk_pkg::SHIFT_W-1:0] amt;
        logic [rgbpk_pkg::PIX_W-1:0]   wide;
        amt  = rgbpk_pkg::SHIFT_W'(-sh);
        wide = rgbpk_pkg::PIX_W'(c);
        if (sh[rgbpk_pkg::SHIFT_W-1]) begin
            return wide >> amt;
        end
        return wide << sh[rgbpk_pkg::SHIFT_W-2:0];
    endfunction

    assign packed_pix = (place(i_chan.r, i_cfg.red_shift)   & i_cfg.red_mask)
                      | (place(i_chan.g, i_cfg.green_shift) & i_cfg.green_mask)
                      | (place(i_chan.b, i_cfg.blue_shift)  & i_cfg.blue_mask);

    always_comb begin
        if (packed_pix != '0) begin
            n_pixel = packed_pix | i_cfg.alpha_mask;
        end else if ((i_chan.r | i_chan.g | i_chan.b) != '0) begin
            n_pixel = rgbpk_pkg::BLACK_STANDIN | i_cfg.alpha_mask;
        end else begin
            n_pixel = '0;
        end
    end

    assign o_ready = !r_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid = r_v;
    assign o_pixel = r_pixel;

endmodule

`default_nettype wire
